### src/lagm_pkg.sv
// ----------------------------------------------------------------------------
// lagm_pkg
// Shared types and codes of the link aggregation mux state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package lagm_pkg;

   // request action codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   // mux machine states, codes as reported in mux_state
   typedef enum logic [2:0] {
      ST_BEGIN    = 3'd0,
      ST_DISABLE  = 3'd1,
      ST_DETACHED = 3'd2,
      ST_WAITING  = 3'd3,
      ST_READY_N  = 3'd4,
      ST_ATTACHED = 3'd5,
      ST_RX_TX    = 3'd6
   } lagm_state_type;

   // one request: a tick or an evaluate with the port conditions
   typedef struct packed {
      logic action;
      logic port_up;
      logic proto_up;
      logic selected;
      logic standby;
      logic partner_sync;
      logic aggregator_ready;
   } lagm_req_type;

   // one result: the machine state after the request
   typedef struct packed {
      logic [2:0] mux_state;
      logic       changed;
      logic       actor_sync;
      logic       actor_collecting;
      logic       actor_distributing;
      logic       attached;
      logic       coll_dist_enable;
      logic       need_to_transmit;
      logic       ready_flag;
   } lagm_rsp_type;

endpackage

`default_nettype wire

### src/lagm_if.sv
// ----------------------------------------------------------------------------
// lagm_if
// Valid/ready channels carrying requests and results of the mux machine.
// ----------------------------------------------------------------------------
`default_nettype none

interface lagm_req_if;
   logic                  valid;
   logic                  ready;
   lagm_pkg::lagm_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lagm_rsp_if;
   logic                  valid;
   logic                  ready;
   lagm_pkg::lagm_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/lagm_in_reg.sv
// ----------------------------------------------------------------------------
// lagm_in_reg
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lagm_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   lagm_req_if.sink              req_chan,
   input  wire logic             take,
   output logic                  held_valid,
   output lagm_pkg::lagm_req_type held_payload
);

   logic                   valid_ff, valid_in;
   lagm_pkg::lagm_req_type payload_ff;
   logic                   accept;

   // free when empty or when the core drains it this cycle
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   // occupancy
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         payload_ff <= req_chan.payload;
      end
   end

   assign held_valid   = valid_ff;
   assign held_payload = payload_ff;

endmodule

`default_nettype wire

### src/lagm_core.sv
// ----------------------------------------------------------------------------
// lagm_core
// Mux state machine: state, flags, wait counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lagm_core #(
   parameter int WAIT_WIDTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   held_valid,
   input  wire lagm_pkg::lagm_req_type held_payload,
   output logic                        take,
   lagm_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [7:0]             csr_wr_data
);

   lagm_pkg::lagm_state_type state_ff, state_in;
   lagm_pkg::lagm_state_type nx;
   logic                     has_next;
   logic [WAIT_WIDTH-1:0]    wait_ff, wait_in;
   logic [WAIT_WIDTH-1:0]    wait_load;
   logic [WAIT_WIDTH+7:0]    wait_ext;
   logic [7:0]               ticks_ff;
   logic sync_ff, sync_in, coll_ff, coll_in, dist_ff, dist_in;
   logic attach_ff, attach_in, cd_ff, cd_in, ntt_ff, ntt_in;
   logic ready_ff, ready_in;
   logic changed_ff, changed_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic active;

   // wait load value fitted to the counter width
   assign wait_ext  = {{WAIT_WIDTH{1'b0}}, ticks_ff};
   assign wait_load = wait_ext[WAIT_WIDTH-1:0];

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= 8'd2;
      end else if (csr_wr_en) begin
         ticks_ff <= csr_wr_data;
      end
   end

   // result slot is free when empty or being taken
   assign take = held_valid && (!rsp_valid_ff || rsp_chan.ready);

   // transition conditions
   assign active = held_payload.selected && !held_payload.standby;

   always_comb begin
      nx       = lagm_pkg::ST_DISABLE;
      has_next = 1'b0;
      if (!held_payload.port_up || !held_payload.proto_up) begin
         has_next = (state_ff != lagm_pkg::ST_DISABLE);
      end else begin
         unique case (state_ff)
            lagm_pkg::ST_BEGIN, lagm_pkg::ST_DISABLE: begin
               nx       = lagm_pkg::ST_DETACHED;
               has_next = 1'b1;
            end
            lagm_pkg::ST_DETACHED: begin
               nx       = lagm_pkg::ST_WAITING;
               has_next = active;
            end
            lagm_pkg::ST_WAITING: begin
               nx       = lagm_pkg::ST_READY_N;
               has_next = (wait_ff == '0);
            end
            lagm_pkg::ST_READY_N: begin
               nx       = active ? lagm_pkg::ST_ATTACHED : lagm_pkg::ST_DETACHED;
               has_next = !active || held_payload.aggregator_ready;
            end
            lagm_pkg::ST_ATTACHED: begin
               nx       = active ? lagm_pkg::ST_RX_TX : lagm_pkg::ST_DETACHED;
               has_next = !active || held_payload.partner_sync;
            end
            lagm_pkg::ST_RX_TX: begin
               nx       = lagm_pkg::ST_ATTACHED;
               has_next = !(active && held_payload.partner_sync);
            end
            default: begin
               has_next = 1'b0;
            end
         endcase
      end
   end

   // state update and entry actions
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      sync_in      = sync_ff;
      coll_in      = coll_ff;
      dist_in      = dist_ff;
      attach_in    = attach_ff;
      cd_in        = cd_ff;
      ntt_in       = ntt_ff;
      ready_in     = ready_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         changed_in   = 1'b0;
         if (held_payload.action == lagm_pkg::ACT_TICK) begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - WAIT_WIDTH'(1);
            end
         end else if (has_next) begin
            state_in   = nx;
            changed_in = 1'b1;
            unique case (nx)
               lagm_pkg::ST_BEGIN, lagm_pkg::ST_DISABLE: begin
                  attach_in = 1'b0;
                  sync_in   = 1'b0;
                  coll_in   = 1'b1;
                  dist_in   = 1'b1;
                  cd_in     = 1'b1;
                  ntt_in    = 1'b0;
               end
               lagm_pkg::ST_DETACHED: begin
                  attach_in = 1'b0;
                  sync_in   = 1'b0;
                  coll_in   = 1'b0;
                  dist_in   = 1'b0;
                  cd_in     = 1'b0;
                  ntt_in    = 1'b1;
               end
               lagm_pkg::ST_WAITING: begin
                  wait_in  = wait_load;
                  ready_in = 1'b0;
               end
               lagm_pkg::ST_READY_N: begin
                  ready_in = 1'b1;
               end
               lagm_pkg::ST_ATTACHED: begin
                  attach_in = 1'b1;
                  sync_in   = 1'b1;
                  coll_in   = 1'b0;
                  dist_in   = 1'b0;
                  cd_in     = 1'b0;
                  ntt_in    = 1'b1;
               end
               lagm_pkg::ST_RX_TX: begin
                  coll_in = 1'b1;
                  dist_in = 1'b1;
                  cd_in   = 1'b1;
                  ntt_in  = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lagm_pkg::ST_BEGIN;
         wait_ff      <= '0;
         sync_ff      <= 1'b0;
         coll_ff      <= 1'b0;
         dist_ff      <= 1'b0;
         attach_ff    <= 1'b0;
         cd_ff        <= 1'b0;
         ntt_ff       <= 1'b0;
         ready_ff     <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         sync_ff      <= sync_in;
         coll_ff      <= coll_in;
         dist_ff      <= dist_in;
         attach_ff    <= attach_in;
         cd_ff        <= cd_in;
         ntt_ff       <= ntt_in;
         ready_ff     <= ready_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state registers double as the result register: they only move on take
   assign rsp_chan.valid                      = rsp_valid_ff;
   assign rsp_chan.payload.mux_state          = state_ff;
   assign rsp_chan.payload.changed            = changed_ff;
   assign rsp_chan.payload.actor_sync         = sync_ff;
   assign rsp_chan.payload.actor_collecting   = coll_ff;
   assign rsp_chan.payload.actor_distributing = dist_ff;
   assign rsp_chan.payload.attached           = attach_ff;
   assign rsp_chan.payload.coll_dist_enable   = cd_ff;
   assign rsp_chan.payload.need_to_transmit   = ntt_ff;
   assign rsp_chan.payload.ready_flag         = ready_ff;

endmodule

`default_nettype wire

### src/link_aggregation_mux_fsm.sv
// ----------------------------------------------------------------------------
// link_aggregation_mux_fsm
// Per-port link aggregation mux state machine with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per handshake: a timer tick (counts the
//   wait counter down, stopping at zero) or an evaluate (at most one state
//   transition plus its entry actions). rsp_chan returns exactly one result
//   per request with the state and flags after it; changed is set when the
//   evaluate moved the machine. Repeat evaluates until changed reads 0.
//   csr_wr_en/csr_wr_data load the wait tick count used on entry to waiting;
//   write it only while no request is in flight.
// Flow:
//   a request lands in the input register at its handshake; once the result
//   slot is free, the state machine update takes it and writes the result
//   register. One request per cycle is sustained while rsp_chan does not
//   stall.
// Reset and stalls:
//   reset empties both registers, puts the machine in begin with all flags
//   clear and the wait load at 2. When rsp_chan stalls the result holds;
//   one more request is taken into the input register, then req ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module link_aggregation_mux_fsm #(
   parameter int WAIT_WIDTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   lagm_req_if.sink        req_chan,
   lagm_rsp_if.source      rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   logic                   held_valid;
   lagm_pkg::lagm_req_type held_payload;
   logic                   take;

   // request holding register
   lagm_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .take         (take),
      .held_valid   (held_valid),
      .held_payload (held_payload)
   );

   // state machine and result register
   lagm_core #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .held_valid   (held_valid),
      .held_payload (held_payload),
      .take         (take),
      .rsp_chan     (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

endmodule

`default_nettype wire

### src/lagm_chk.sv
// ----------------------------------------------------------------------------
// lagm_chk
// Port-level checks of the mux state machine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lagm_chk (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire lagm_pkg::lagm_rsp_type rsp_payload
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // attached and rx_tx report the port attached and in sync
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.mux_state == lagm_pkg::ST_ATTACHED ||
                    rsp_payload.mux_state == lagm_pkg::ST_RX_TX)
      |-> rsp_payload.attached && rsp_payload.actor_sync)
      else $error("attached state without attach flags");

   // rx_tx enables collecting and distributing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mux_state == lagm_pkg::ST_RX_TX
      |-> rsp_payload.actor_collecting && rsp_payload.actor_distributing &&
          rsp_payload.coll_dist_enable)
      else $error("rx_tx without collecting and distributing");

   // detached drops attach and sync
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mux_state == lagm_pkg::ST_DETACHED
      |-> !rsp_payload.attached && !rsp_payload.actor_sync)
      else $error("detached state still attached");

endmodule

bind link_aggregation_mux_fsm lagm_chk u_lagm_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire
